[rtl/rmst_pkg.sv]
package rmst_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 10;
  localparam int CNT_W = 11;
  localparam int STAT_W = 2;

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] WRITE_RESULT = 32'h0000_0000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_WRITE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_QUERY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_DOWN,
    ST_W_READ,
    ST_W_WRITE,
    ST_Q_VISIT,
    ST_Q_DRAIN
  } state_t;

  function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

[rtl/range_max_segment_tree.sv]
// Max segment tree over up to MAX_ELEMENTS signed 32-bit elements, one
// operation per transfer. After reset the block clears all 4*MAX_ELEMENTS
// tree nodes, one a cycle, with busy high. A transfer is taken when start is
// high and busy low; its single result appears on max_value and status for
// one cycle with done high and must be taken then, as the receiver cannot
// stall. An invalid item is answered in the cycle after the transfer. A write
// walks down to the leaf and writes it, then, a level at a time on the way up,
// reads the sibling and writes the parent through the single node memory, then
// gives its result; a query visits nodes in turn, then drains and gives its
// result. element_count may be changed only while busy is low.
module range_max_segment_tree #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rmst_pkg::CNT_W-1:0]         cfg_wdata,
  input  logic                               start,
  input  logic                               opcode,
  input  logic [rmst_pkg::POS_W-1:0]         position,
  input  logic [rmst_pkg::POS_W-1:0]         range_end,
  input  logic signed [rmst_pkg::VAL_W-1:0]  value,
  output logic                               busy,
  output logic                               done,
  output logic signed [rmst_pkg::VAL_W-1:0]  max_value,
  output logic [rmst_pkg::STAT_W-1:0]        status
);

  localparam int NODE_DEPTH = 4 * MAX_ELEMENTS;
  localparam int AW = $clog2(NODE_DEPTH);
  localparam int CW = rmst_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_CAP =
    (MAX_ELEMENTS >= (1 << CW)) ? '1 : CW'(MAX_ELEMENTS);

  logic [CW-1:0] element_count;
  logic [CW-1:0] count_eff;

  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [rmst_pkg::VAL_W-1:0] mem_wdata, mem_rdata;
  logic [rmst_pkg::VAL_W-1:0] res_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= rmst_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  assign count_eff = (element_count > CNT_CAP) ? CNT_CAP : element_count;
  assign max_value = $signed(res_val);

  rmst_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .NODE_DEPTH(NODE_DEPTH),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .count_eff(count_eff),
    .start(start),
    .opcode(opcode),
    .position(position),
    .range_end(range_end),
    .value(rmst_pkg::VAL_W'(value)),
    .busy(busy),
    .done(done),
    .max_value(res_val),
    .status(status),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  rmst_node_ram #(
    .DEPTH(NODE_DEPTH),
    .AW(AW)
  ) u_node_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

[rtl/rmst_node_ram.sv]
module rmst_node_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [rmst_pkg::VAL_W-1:0]    wdata,
  input  logic                          re,
  input  logic [AW-1:0]                 raddr,
  output logic [rmst_pkg::VAL_W-1:0]    rdata
);

  logic [rmst_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rmst_ctrl.sv]
module rmst_ctrl #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int NODE_DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [rmst_pkg::CNT_W-1:0]         count_eff,
  input  logic                               start,
  input  logic                               opcode,
  input  logic [rmst_pkg::POS_W-1:0]         position,
  input  logic [rmst_pkg::POS_W-1:0]         range_end,
  input  logic [rmst_pkg::VAL_W-1:0]         value,
  output logic                               busy,
  output logic                               done,
  output logic [rmst_pkg::VAL_W-1:0]         max_value,
  output logic [rmst_pkg::STAT_W-1:0]        status,
  output logic                               mem_we,
  output logic [AW-1:0]                      mem_waddr,
  output logic [rmst_pkg::VAL_W-1:0]         mem_wdata,
  output logic                               mem_re,
  output logic [AW-1:0]                      mem_raddr,
  input  logic [rmst_pkg::VAL_W-1:0]         mem_rdata
);

  localparam int SD = $clog2(MAX_ELEMENTS) + 1;
  localparam int SIW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);
  localparam int PW = rmst_pkg::CNT_W;
  localparam int VW = rmst_pkg::VAL_W;

  rmst_pkg::state_t state, state_next;

  logic [AW-1:0]  clr_addr;
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_m1;
  logic           rd_pend;
  logic           done_next;
  logic [VW-1:0]  res_val;
  logic [rmst_pkg::STAT_W-1:0] res_stat;

  logic [PW-1:0] s, e, qs, qe;
  logic [AW-1:0] k;
  logic [VW-1:0] cur, acc;

  logic [PW-1:0] s_stk [SD];
  logic [PW-1:0] e_stk [SD];
  logic [AW-1:0] k_stk [SD];

  logic [PW-1:0] mid, n_m1;
  logic [AW-1:0] lchild, rchild, sibling, parent;
  logic [VW-1:0] up_max, acc_fin;
  logic          pos_ok, end_ok, order_ok, write_ok, query_ok;
  logic          disjoint, contained, settled;
  logic          stk_push, stk_pop;

  assign busy = (state != rmst_pkg::ST_IDLE);

  assign mid = s + ((e - s) >> 1);
  assign n_m1 = PW'(count_eff - rmst_pkg::CNT_W'(1));
  assign lchild = AW'({k, 1'b1});
  assign rchild = AW'({k, 1'b0} + (AW + 1)'(2));
  assign sibling = k[0] ? (k + AW'(1)) : (k - AW'(1));
  assign parent = (k - AW'(1)) >> 1;
  assign up_max = rmst_pkg::smax(cur, mem_rdata);
  assign acc_fin = rd_pend ? rmst_pkg::smax(acc, mem_rdata) : acc;
  assign sp_m1 = sp - SPW'(1);

  assign pos_ok = rmst_pkg::CNT_W'(position) < count_eff;
  assign end_ok = rmst_pkg::CNT_W'(range_end) < count_eff;
  assign order_ok = position <= range_end;
  assign write_ok = (opcode == rmst_pkg::OP_WRITE) && pos_ok;
  assign query_ok = (opcode == rmst_pkg::OP_QUERY) && pos_ok && end_ok && order_ok;

  assign disjoint = (e < qs) || (qe < s);
  assign contained = (qs <= s) && (e <= qe);
  assign settled = disjoint || contained;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rmst_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(NODE_DEPTH - 1)) state_next = rmst_pkg::ST_IDLE;
      end
      rmst_pkg::ST_IDLE: begin
        if (start && write_ok) state_next = rmst_pkg::ST_W_DOWN;
        else if (start && query_ok) state_next = rmst_pkg::ST_Q_VISIT;
      end
      rmst_pkg::ST_W_DOWN: begin
        if (s == e) state_next = rmst_pkg::ST_W_READ;
      end
      rmst_pkg::ST_W_READ: begin
        if (k == '0) state_next = rmst_pkg::ST_IDLE;
        else state_next = rmst_pkg::ST_W_WRITE;
      end
      rmst_pkg::ST_W_WRITE: begin
        state_next = rmst_pkg::ST_W_READ;
      end
      rmst_pkg::ST_Q_VISIT: begin
        if (settled && (sp == '0)) state_next = rmst_pkg::ST_Q_DRAIN;
      end
      rmst_pkg::ST_Q_DRAIN: begin
        state_next = rmst_pkg::ST_IDLE;
      end
      default: begin
        state_next = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  // memory and stack controls
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = k;
    mem_wdata = cur;
    mem_re = 1'b0;
    mem_raddr = k;
    stk_push = 1'b0;
    stk_pop = 1'b0;
    case (state)
      rmst_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = rmst_pkg::INT_MIN;
      end
      rmst_pkg::ST_W_DOWN: begin
        mem_we = (s == e);
      end
      rmst_pkg::ST_W_READ: begin
        mem_re = (k != '0);
        mem_raddr = sibling;
      end
      rmst_pkg::ST_W_WRITE: begin
        mem_we = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_max;
      end
      rmst_pkg::ST_Q_VISIT: begin
        mem_re = contained;
        stk_push = !settled;
        stk_pop = settled && (sp != '0);
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    done_next = 1'b0;
    res_val = rmst_pkg::MINUS_ONE;
    res_stat = rmst_pkg::STAT_INVALID;
    case (state)
      rmst_pkg::ST_IDLE: begin
        done_next = start && !write_ok && !query_ok;
      end
      rmst_pkg::ST_W_READ: begin
        done_next = (k == '0);
        res_val = rmst_pkg::WRITE_RESULT;
        res_stat = rmst_pkg::STAT_WRITE;
      end
      rmst_pkg::ST_Q_DRAIN: begin
        done_next = 1'b1;
        res_val = acc_fin;
        res_stat = rmst_pkg::STAT_QUERY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmst_pkg::ST_CLEAR;
      clr_addr <= '0;
      sp <= '0;
      rd_pend <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
      rd_pend <= (state == rmst_pkg::ST_Q_VISIT) && mem_re;
      if (state == rmst_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == rmst_pkg::ST_IDLE) begin
        sp <= '0;
      end else if (stk_push) begin
        sp <= sp + SPW'(1);
      end else if (stk_pop) begin
        sp <= sp_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      max_value <= res_val;
      status <= res_stat;
    end
    if (stk_push) begin
      s_stk[sp[SIW-1:0]] <= mid + PW'(1);
      e_stk[sp[SIW-1:0]] <= e;
      k_stk[sp[SIW-1:0]] <= rchild;
    end
    case (state)
      rmst_pkg::ST_IDLE: begin
        if (start) begin
          s <= '0;
          e <= n_m1;
          k <= '0;
          qs <= PW'(position);
          qe <= PW'(range_end);
          cur <= value;
          acc <= rmst_pkg::INT_MIN;
        end
      end
      rmst_pkg::ST_W_DOWN: begin
        if (s != e) begin
          if (qs <= mid) begin
            e <= mid;
            k <= lchild;
          end else begin
            s <= mid + PW'(1);
            k <= rchild;
          end
        end
      end
      rmst_pkg::ST_W_WRITE: begin
        cur <= up_max;
        k <= parent;
      end
      rmst_pkg::ST_Q_VISIT: begin
        acc <= acc_fin;
        if (!settled) begin
          e <= mid;
          k <= lchild;
        end else if (stk_pop) begin
          s <= s_stk[sp_m1[SIW-1:0]];
          e <= e_stk[sp_m1[SIW-1:0]];
          k <= k_stk[sp_m1[SIW-1:0]];
        end
      end
      rmst_pkg::ST_Q_DRAIN: begin
        acc <= acc_fin;
      end
      default: begin
      end
    endcase
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  a_transfer_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transfer neither started nor answered");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stk_push |-> (sp < SPW'(SD)))
    else $error("stack overflow");

  a_invalid_value: assert property (@(posedge clk) disable iff (rst)
    (done && (status == rmst_pkg::STAT_INVALID)) |-> (max_value == rmst_pkg::MINUS_ONE))
    else $error("invalid result without minus one");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == rmst_pkg::ST_CLEAR) || (state == rmst_pkg::ST_W_DOWN) ||
                (state == rmst_pkg::ST_W_WRITE)))
    else $error("tree written outside a write");

endmodule

[tb/range_max_segment_tree_tb.sv]
module range_max_segment_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TREE_NODES = 4096;
  localparam int ELEM_LIMIT = 1024;
  localparam logic [rmst_pkg::VAL_W-1:0] INT_MAX_VAL = 32'h7FFF_FFFF;

  typedef struct {
    logic                       op;
    logic [rmst_pkg::POS_W-1:0] pos;
    logic [rmst_pkg::POS_W-1:0] end_pos;
    logic [rmst_pkg::VAL_W-1:0] val;
  } tree_op_t;

  typedef struct {
    logic [rmst_pkg::VAL_W-1:0]  max_value;
    logic [rmst_pkg::STAT_W-1:0] status;
  } tree_answer_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rmst_pkg::CNT_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic opcode = 1'b0;
  logic [rmst_pkg::POS_W-1:0] position = '0;
  logic [rmst_pkg::POS_W-1:0] range_end = '0;
  logic signed [rmst_pkg::VAL_W-1:0] value = '0;
  logic busy;
  logic done;
  logic signed [rmst_pkg::VAL_W-1:0] max_value;
  logic [rmst_pkg::STAT_W-1:0] status;

  range_max_segment_tree #(.MAX_ELEMENTS(ELEM_LIMIT)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .opcode    (opcode),
    .position  (position),
    .range_end (range_end),
    .value     (value),
    .busy      (busy),
    .done      (done),
    .max_value (max_value),
    .status    (status)
  );

  logic [rmst_pkg::VAL_W-1:0] tree_node [0:TREE_NODES-1];
  logic [rmst_pkg::CNT_W-1:0] count_cfg;
  tree_op_t queued_ops[$];
  tree_answer_t awaited_answers[$];
  tree_op_t cur_op;
  int unsigned idle_left = 0;
  bit no_gaps = 1'b0;
  int errors = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [rmst_pkg::VAL_W-1:0] larger(logic [rmst_pkg::VAL_W-1:0] a,
                                                        logic [rmst_pkg::VAL_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic logic [rmst_pkg::VAL_W-1:0] node_at(int unsigned k);
    return (k < TREE_NODES) ? tree_node[k] : rmst_pkg::INT_MIN;
  endfunction

  function automatic int unsigned active_count();
    return (count_cfg > ELEM_LIMIT) ? ELEM_LIMIT : count_cfg;
  endfunction

  function automatic tree_answer_t apply_op(tree_op_t t);
    int unsigned n, s, e, k, m, p;
    int unsigned span_lo[64], span_hi[64], span_node[64];
    int unsigned path[64];
    int depth;
    logic [rmst_pkg::VAL_W-1:0] peak;
    tree_answer_t a;
    n = active_count();
    a.max_value = rmst_pkg::MINUS_ONE;
    a.status = rmst_pkg::STAT_INVALID;
    if (t.op == rmst_pkg::OP_WRITE) begin
      if (t.pos < n) begin
        // walk down to the leaf, then rebuild maxima back up to the root
        s = 0;
        e = n - 1;
        k = 0;
        depth = 0;
        while (s != e) begin
          path[depth] = k;
          depth++;
          m = s + (e - s) / 2;
          if (t.pos <= m) begin
            e = m;
            k = 2 * k + 1;
          end else begin
            s = m + 1;
            k = 2 * k + 2;
          end
        end
        if (k < TREE_NODES) tree_node[k] = t.val;
        for (int i = depth - 1; i >= 0; i--) begin
          p = path[i];
          if (p < TREE_NODES) tree_node[p] = larger(node_at(2 * p + 1), node_at(2 * p + 2));
        end
        a.max_value = rmst_pkg::WRITE_RESULT;
        a.status = rmst_pkg::STAT_WRITE;
      end
    end else if (t.pos < n && t.end_pos < n && t.pos <= t.end_pos) begin
      peak = rmst_pkg::INT_MIN;
      depth = 1;
      span_lo[0] = 0;
      span_hi[0] = n - 1;
      span_node[0] = 0;
      while (depth > 0) begin
        depth--;
        s = span_lo[depth];
        e = span_hi[depth];
        k = span_node[depth];
        if (!(e < t.pos || t.end_pos < s)) begin
          if (t.pos <= s && e <= t.end_pos) begin
            peak = larger(peak, node_at(k));
          end else begin
            m = s + (e - s) / 2;
            span_lo[depth] = s;
            span_hi[depth] = m;
            span_node[depth] = 2 * k + 1;
            span_lo[depth + 1] = m + 1;
            span_hi[depth + 1] = e;
            span_node[depth + 1] = 2 * k + 2;
            depth += 2;
          end
        end
      end
      a.max_value = peak;
      a.status = rmst_pkg::STAT_QUERY;
    end
    return a;
  endfunction

  function automatic tree_op_t mk(logic op, int unsigned pos, int unsigned end_pos,
                                  logic [rmst_pkg::VAL_W-1:0] val);
    tree_op_t t;
    t.op = op;
    t.pos = pos[rmst_pkg::POS_W-1:0];
    t.end_pos = end_pos[rmst_pkg::POS_W-1:0];
    t.val = val;
    return t;
  endfunction

  function automatic logic [rmst_pkg::VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return rmst_pkg::INT_MIN;
      1: return INT_MAX_VAL;
      2: return rmst_pkg::MINUS_ONE;
      3: return '0;
      4, 5: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_quiet();
    do @(negedge clk);
    while (queued_ops.size() != 0 || start || awaited_answers.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_count(input logic [rmst_pkg::CNT_W-1:0] v);
    wait_quiet();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_cfg = v;
    @(negedge clk);
  endtask

  task automatic random_phase(input logic [rmst_pkg::CNT_W-1:0] cnt, input int items);
    int unsigned n, r, p, q;
    tree_op_t t;
    write_count(cnt);
    no_gaps = ($urandom_range(0, 3) == 0);
    n = active_count();
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (n == 0 || r < 15) begin
        t = mk(($urandom_range(0, 1) == 0) ? rmst_pkg::OP_WRITE : rmst_pkg::OP_QUERY,
               $urandom, $urandom, $urandom);
      end else if (r < 55) begin
        p = $urandom_range(0, n - 1);
        t = mk(rmst_pkg::OP_WRITE, p, $urandom, rand_value());
      end else begin
        p = $urandom_range(0, n - 1);
        case ($urandom_range(0, 3))
          0: q = (p + 3 < n) ? p + $urandom_range(0, 3) : n - 1;
          1: begin
            p = 0;
            q = n - 1;
          end
          default: q = $urandom_range(p, n - 1);
        endcase
        t = mk(rmst_pkg::OP_QUERY, p, q, $urandom);
      end
      queued_ops.push_back(t);
    end
  endtask

  // driver: one item per transfer, random gap after each
  always @(posedge clk) begin : drive_proc
    int unsigned roll;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_answers.push_back(apply_op(cur_op));
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55) idle_left = 0;
        else if (roll < 90) idle_left = $urandom_range(1, 3);
        else idle_left = $urandom_range(5, 60);
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (queued_ops.size() > 0) begin
          cur_op = queued_ops.pop_front();
          opcode <= cur_op.op;
          position <= cur_op.pos;
          range_end <= cur_op.end_pos;
          value <= cur_op.val;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    tree_answer_t want;
    if (!rst && done) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual max_value=%0d status=%0d",
                 $time, max_value, status);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        if (max_value !== want.max_value) begin
          $display("%0t: max_value mismatch, expected %0d, actual %0d",
                   $time, $signed(want.max_value), max_value);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TREE_NODES; i++) tree_node[i] = rmst_pkg::INT_MIN;
    count_cfg = rmst_pkg::COUNT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (rst || busy !== 1'b0);

    // cleared tree at reset count, extremes of value and index
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 1023, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 0, 0, INT_MAX_VAL));
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 1023, 1023, rmst_pkg::INT_MIN));
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 512, 0, rmst_pkg::MINUS_ONE));
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 5, 1023, '0));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 1023, rmst_pkg::MINUS_ONE));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 1, 1022, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 1023, 1023, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 512, 512, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 10, 9, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 0, 0));

    // zero count, all invalid
    write_count(0);
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 0, 0, 5));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 0, 0));

    // oversized count saturates
    write_count(11'd2047);
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 1023, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 1000, 1023, 0));

    // single element
    write_count(1);
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 0, 0, -7));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 0, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 1, 0, 3));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 1, 0));

    // shape change over stale nodes
    write_count(3);
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 0, 2, 0));
    queued_ops.push_back(mk(rmst_pkg::OP_WRITE, 2, 0, 9));
    queued_ops.push_back(mk(rmst_pkg::OP_QUERY, 1, 2, 0));

    random_phase(11'd1024, 135);
    random_phase(11'd2, 135);
    random_phase(11'd1, 135);
    random_phase(11'd1500, 135);
    random_phase(11'd37, 135);
    random_phase(11'd513, 135);
    random_phase(11'd0, 40);
    random_phase(11'd2047, 135);
    random_phase(11'd700, 135);
    random_phase(11'd1023, 135);
    random_phase(11'd64, 135);
    random_phase(11'd999, 135);

    wait_quiet();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
